// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on the rising clock, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clock, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tlnef_pkg.sv
// shared types, byte codes and register indexes for the line number / escape filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlnef_pkg;

    localparam int LINE_DIGITS_DEF = 10;
    localparam int NUM_WIDTH       = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_ALL  = 2'd1;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_CAP_I  = 8'h49;
    localparam logic [7:0] CH_CAP_M  = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_OFS = 8'h40;

    typedef enum logic [1:0] {
        PRE_NONE  = 2'd0,
        PRE_CARET = 2'd1,
        PRE_META  = 2'd2
    } t_prefix;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       show_ends;
        logic       squeeze_blank;
        logic       show_tabs;
        logic       show_nonprinting;
    } t_cfg;

    // what one item has to print, apart from the line number digits
    typedef struct packed {
        logic       num;
        logic       dollar;
        t_prefix    pre;
        logic [7:0] ch;
    } t_job_ctl;

endpackage

`default_nettype wire

// File: sv/tlnef_front.sv
// input stage: line state, bcd counter and escape decode into a job register
// depends on tlnef_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlnef_front import tlnef_pkg::*; #(
    parameter int LINE_DIGITS = LINE_DIGITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cfg                            i_cfg,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_byte,
    input  wire logic                            i_file_start,
    output logic                                 o_job_valid,
    input  wire logic                            i_job_ready,
    output t_job_ctl                             o_job_ctl,
    output logic [LINE_DIGITS-1:0][3:0]          o_job_digits,
    output logic [$clog2(LINE_DIGITS+1)-1:0]     o_job_sig,
    output logic [$clog2(LINE_DIGITS)-1:0]       o_job_top
);

    localparam int SW = $clog2(LINE_DIGITS + 1);
    localparam int PW = $clog2(LINE_DIGITS);

    logic                        r_after_nl;
    logic                        r_blank;
    logic [LINE_DIGITS-1:0][3:0] r_digits;
    logic                        r_job_valid;
    t_job_ctl                    r_job_ctl;
    logic [LINE_DIGITS-1:0][3:0] r_job_digits;
    logic [SW-1:0]               r_job_sig;
    logic [PW-1:0]               r_job_top;

    logic                        accept;
    logic                        prev_nl;
    logic                        blank;
    logic [LINE_DIGITS-1:0][3:0] digs;
    logic                        nl;
    logic                        squeeze;
    logic                        do_num;
    logic                        low_nine;
    logic [LINE_DIGITS-1:0][3:0] inc_digs;
    logic [LINE_DIGITS-1:0][3:0] n_digits;
    logic [SW-1:0]               sig;
    logic [PW-1:0]               top;
    t_job_ctl                    ctl;

    assign o_ready = !r_job_valid || i_job_ready;
    assign accept  = i_valid && o_ready;

    // a file start clears the line state before this item is looked at
    assign prev_nl = i_file_start ? 1'b1 : r_after_nl;
    assign blank   = i_file_start ? 1'b0 : r_blank;
    assign digs    = i_file_start ? '0 : r_digits;
    assign nl      = (i_byte == CH_NL);
    assign squeeze = i_cfg.squeeze_blank && prev_nl && nl && blank;

    always_comb begin
        if (i_cfg.number_mode == NUM_ALL) begin
            do_num = prev_nl;
        end else if (i_cfg.number_mode[1]) begin
            do_num = prev_nl && !nl;
        end else begin
            do_num = 1'b0;
        end
        do_num = do_num && !squeeze;
    end

    // bcd increment, saturating at all nines
    always_comb begin
        low_nine = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (low_nine) begin
                inc_digs[i] = (digs[i] >= 4'd9) ? 4'd0 : digs[i] + 4'd1;
            end else begin
                inc_digs[i] = digs[i];
            end
            low_nine = low_nine && (digs[i] >= 4'd9);
        end
        n_digits = (do_num && !low_nine) ? inc_digs : digs;
    end

    always_comb begin
        sig = SW'(1);
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (n_digits[i] != 4'd0) begin
                sig = SW'(i + 1);
            end
        end
        top = (sig > SW'(NUM_WIDTH)) ? PW'(sig - SW'(1)) : PW'(NUM_WIDTH - 1);
    end

    always_comb begin
        ctl.num    = do_num;
        ctl.dollar = i_cfg.show_ends && nl;
        ctl.pre    = PRE_NONE;
        ctl.ch     = i_byte;
        if (i_cfg.show_tabs && i_byte == CH_TAB) begin
            ctl.pre = PRE_CARET;
            ctl.ch  = CH_CAP_I;
        end else if (i_cfg.show_nonprinting && !nl && i_byte != CH_TAB) begin
            if (i_byte[7:5] == 3'b100) begin
                ctl.pre = PRE_META;
                ctl.ch  = i_byte - CH_CTRL_OFS;
            end else if (i_byte[7:5] == 3'b000) begin
                ctl.pre = PRE_CARET;
                ctl.ch  = i_byte + CH_CTRL_OFS;
            end else if (i_byte == CH_DEL) begin
                ctl.pre = PRE_CARET;
                ctl.ch  = CH_QMARK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_nl  <= 1'b1;
            r_blank     <= 1'b0;
            r_digits    <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (i_job_ready) begin
                r_job_valid <= 1'b0;
            end
            if (accept) begin
                r_after_nl <= nl;
                r_digits   <= n_digits;
                // a squeezed line leaves the blank flag as it was
                if (!squeeze) begin
                    r_blank      <= prev_nl && nl;
                    r_job_valid  <= 1'b1;
                    r_job_ctl    <= ctl;
                    r_job_digits <= n_digits;
                    r_job_sig    <= sig;
                    r_job_top    <= top;
                end else begin
                    r_blank <= blank;
                end
            end
        end
    end

    assign o_job_valid  = r_job_valid;
    assign o_job_ctl    = r_job_ctl;
    assign o_job_digits = r_job_digits;
    assign o_job_sig    = r_job_sig;
    assign o_job_top    = r_job_top;

    `ASSERT_CLK(a_squeeze_no_job, i_clk, i_rst_n, accept && squeeze |=> !r_job_valid, "squeezed item left a job")
    `ASSERT_CLK(a_nl_state, i_clk, i_rst_n, accept && nl |=> r_after_nl, "newline not recorded")

endmodule

`default_nettype wire

// File: sv/tlnef_emit.sv
// burst sequencer: walks one job through its output bytes into the result register
// depends on tlnef_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlnef_emit import tlnef_pkg::*; #(
    parameter int LINE_DIGITS = LINE_DIGITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_job_valid,
    output logic                                 o_job_ready,
    input  wire t_job_ctl                        i_job_ctl,
    input  wire logic [LINE_DIGITS-1:0][3:0]     i_job_digits,
    input  wire logic [$clog2(LINE_DIGITS+1)-1:0] i_job_sig,
    input  wire logic [$clog2(LINE_DIGITS)-1:0]  i_job_top,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [7:0]                           o_byte,
    output logic                                 o_last
);

    localparam int SW = $clog2(LINE_DIGITS + 1);
    localparam int PW = $clog2(LINE_DIGITS);

    typedef enum logic [2:0] {
        PH_NUM = 3'd0,
        PH_TAB = 3'd1,
        PH_DOL = 3'd2,
        PH_MET = 3'd3,
        PH_DSH = 3'd4,
        PH_CRT = 3'd5,
        PH_CHR = 3'd6
    } t_phase;

    logic                        r_busy;
    t_phase                      r_phase;
    logic [PW-1:0]               r_pos;
    t_job_ctl                    r_ctl;
    logic [LINE_DIGITS-1:0][3:0] r_digits;
    logic [SW-1:0]               r_sig;
    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;
    logic                        r_out_last;

    logic       out_free;
    logic       step;
    logic       load;
    logic [7:0] cur_byte;
    t_phase     n_phase;
    t_phase     first_phase;

    function automatic logic [6:0] phase_en(input t_job_ctl c);
        phase_en = {1'b1, c.pre != PRE_NONE, c.pre == PRE_META, c.pre == PRE_META,
                    c.dollar, c.num, c.num};
    endfunction

    // first enabled phase at or after start
    function automatic t_phase seek(input t_phase start, input logic [6:0] en);
        t_phase res;
        res = PH_CHR;
        for (int i = 6; i >= 0; i--) begin
            if (en[i] && 3'(i) >= start) begin
                res = t_phase'(3'(i));
            end
        end
        return res;
    endfunction

    assign out_free    = !r_out_valid || i_ready;
    assign step        = r_busy && out_free;
    assign load        = !r_busy || (step && r_phase == PH_CHR);
    assign o_job_ready = load;
    assign first_phase = seek(PH_NUM, phase_en(i_job_ctl));

    always_comb begin
        if (r_phase == PH_NUM && r_pos != '0) begin
            n_phase = PH_NUM;
        end else begin
            n_phase = seek(t_phase'(r_phase + 3'd1), phase_en(r_ctl));
        end
    end

    always_comb begin
        case (r_phase)
            PH_NUM: begin
                if (SW'(r_pos) >= r_sig) begin
                    cur_byte = CH_SPACE;
                end else begin
                    cur_byte = CH_ZERO + {4'd0, r_digits[r_pos]};
                end
            end
            PH_TAB:  cur_byte = CH_TAB;
            PH_DOL:  cur_byte = CH_DOLLAR;
            PH_MET:  cur_byte = CH_CAP_M;
            PH_DSH:  cur_byte = CH_DASH;
            PH_CRT:  cur_byte = CH_CARET;
            PH_CHR:  cur_byte = r_ctl.ch;
            default: cur_byte = r_ctl.ch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_CHR;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= step;
                r_out_byte  <= cur_byte;
                r_out_last  <= (r_phase == PH_CHR);
            end
            if (load) begin
                r_busy <= i_job_valid;
                if (i_job_valid) begin
                    r_phase  <= first_phase;
                    r_pos    <= i_job_top;
                    r_ctl    <= i_job_ctl;
                    r_digits <= i_job_digits;
                    r_sig    <= i_job_sig;
                end
            end else if (step) begin
                r_phase <= n_phase;
                if (r_phase == PH_NUM) begin
                    r_pos <= r_pos - PW'(1);
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    `ASSERT_CLK(a_job_taken, i_clk, i_rst_n, load && i_job_valid |=> r_busy, "job not taken")
    `ASSERT_CLK(a_last_marks_chr, i_clk, i_rst_n, step && r_phase == PH_CHR |=> r_out_valid && r_out_last, "final byte not marked last")
    `ASSERT_CLK(a_num_needs_flag, i_clk, i_rst_n, r_busy && r_phase == PH_NUM |-> r_ctl.num, "number phase without numbering")

endmodule

`default_nettype wire

// File: sv/text_line_number_escape_filter_core.sv
// Text line number and escape filter, top level.
// Slave stream: one text byte per item in s_axis_tdata, file start flag in s_axis_tuser.
// Master stream: formatted bytes, one per item; m_axis_tlast marks the final byte that
// one input byte causes. A squeezed empty line causes no output at all.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data, write only; the user is to write
// it only while idle, which the block itself does not enforce.
// Throughput: one output byte per cycle from the burst sequencer while the receiver takes
// them; an item causes 1 byte for a plain byte, up to 4 for an escape, and
// max(6, significant digits) + 1 more when a line number is printed (at most 15).
// The input side is decoupled by a one-entry job register, so a byte is accepted while
// the previous burst is still going out; the output register parts the receiver side.
// When the receiver stalls the output register holds and the sequencer and then the
// input side stop in turn; nothing is dropped.
// Reset (synchronous, active low): configuration and valid flags cleared, line counter
// zero, state as if a newline had just been seen, no item pending.
// depends on tlnef_pkg, tlnef_front, tlnef_emit
`timescale 1ns / 1ps
`default_nettype none

module text_line_number_escape_filter_core import tlnef_pkg::*; #(
    parameter int LINE_DIGITS = LINE_DIGITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,  // [7:0] text_byte
    input  wire logic                  s_axis_tuser,  // [0] file_start
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // [7:0] out_byte
    output logic                       m_axis_tlast
);

    localparam int SW = $clog2(LINE_DIGITS + 1);
    localparam int PW = $clog2(LINE_DIGITS);

    t_cfg                        r_cfg;
    logic                        job_valid;
    logic                        job_ready;
    t_job_ctl                    job_ctl;
    logic [LINE_DIGITS-1:0][3:0] job_digits;
    logic [SW-1:0]               job_sig;
    logic [PW-1:0]               job_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUMBER_MODE:      r_cfg.number_mode      <= i_cfg_data;
                REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data[0];
                REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data[0];
                REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tlnef_front #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_file_start (s_axis_tuser),
        .o_job_valid  (job_valid),
        .i_job_ready  (job_ready),
        .o_job_ctl    (job_ctl),
        .o_job_digits (job_digits),
        .o_job_sig    (job_sig),
        .o_job_top    (job_top)
    );

    tlnef_emit #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .o_job_ready  (job_ready),
        .i_job_ctl    (job_ctl),
        .i_job_digits (job_digits),
        .i_job_sig    (job_sig),
        .i_job_top    (job_top),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire
